[rtl/altlpc_pkg.sv]
// ----------------------------------------------------------------------------
// altlpc_pkg
// Shared types and constants of the altimeter line pressure compensation
// block: character codes, register indexes, controller states and the
// command and status bundles between its modules.
// ----------------------------------------------------------------------------
package altlpc_pkg;

	// Characters of the text line
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Field widths of one result item
	localparam int P_W     = 25;
	localparam int T_W     = 19;
	localparam int COEFF_W = 16;
	// Width of one multiplier operand slice
	localparam int MB_W    = 23;

	// Compensation constants
	localparam int TEMP_BASE  = 2000;
	localparam int TEMP_LIMIT = 140000;
	localparam int P_MAX      = 16777215;
	localparam int P_MIN      = -16777216;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SENS      = 3'd0;
	localparam logic [2:0] REG_OFFSET    = 3'd1;
	localparam logic [2:0] REG_SENS_TEMP = 3'd2;
	localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
	localparam logic [2:0] REG_REF_TEMP  = 3'd4;
	localparam logic [2:0] REG_SLOPE     = 3'd5;

	// Register reset values
	localparam logic [COEFF_W-1:0] RST_SENS      = 16'd44294;
	localparam logic [COEFF_W-1:0] RST_OFFSET    = 16'd39431;
	localparam logic [COEFF_W-1:0] RST_SENS_TEMP = 16'd26604;
	localparam logic [COEFF_W-1:0] RST_OFF_TEMP  = 16'd24096;
	localparam logic [COEFF_W-1:0] RST_REF_TEMP  = 16'd31503;
	localparam logic [COEFF_W-1:0] RST_SLOPE     = 16'd27302;

	typedef struct packed {
		logic [COEFF_W-1:0] sens_coeff;
		logic [COEFF_W-1:0] offset_coeff;
		logic [COEFF_W-1:0] sens_temp_coeff;
		logic [COEFF_W-1:0] offset_temp_coeff;
		logic [COEFF_W-1:0] ref_temp_coeff;
		logic [COEFF_W-1:0] temp_slope_coeff;
	} coeff_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_T,
		ST_MUL_O,
		ST_MUL_S,
		ST_SENS,
		ST_MUL_PL,
		ST_MUL_PH,
		ST_PSUM,
		ST_PDIFF,
		ST_DONE
	} state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_T,
		OP_MUL_O,
		OP_MUL_S,
		OP_SENS,
		OP_MUL_PL,
		OP_MUL_PH,
		OP_PSUM,
		OP_PDIFF,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	// Line status seen by the controller for the byte on the input
	typedef struct packed {
		logic line_end;
		logic malformed;
	} pstat_t;

endpackage

[rtl/altlpc_parser.sv]
// ----------------------------------------------------------------------------
// altlpc_parser
// Byte parser of the altimeter text line: counts bytes and commas, finds
// the CR LF line end and accumulates the raw pressure and temperature
// readings from the leading digits of the fourth and fifth fields.
// ----------------------------------------------------------------------------
module altlpc_parser
	import altlpc_pkg::*;
#(
	parameter int LINE_MAX     = 256,
	parameter int READING_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              rx_byte,
	output pstat_t                  pstat,
	output logic [READING_BITS-1:0] raw_pressure,
	output logic [READING_BITS-1:0] raw_temperature
);

	localparam int LEN_W = $clog2(LINE_MAX + 1);
	localparam int ACC_W = READING_BITS + 4;

	logic [LEN_W-1:0]        line_len_q;
	logic [2:0]              comma_cnt_q;
	logic                    prev_cr_q;
	logic                    digits_q;
	logic [READING_BITS-1:0] raw_p_q;
	logic [READING_BITS-1:0] raw_t_q;

	logic                    is_digit;
	logic                    line_full;
	logic [2:0]              comma_next;
	logic [READING_BITS-1:0] acc_sel;
	logic [ACC_W-1:0]        acc_sum;
	logic [READING_BITS-1:0] acc_next;

	// Classify the byte on the input
	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign line_full = line_len_q >= LEN_W'(LINE_MAX);

	assign pstat.line_end  = (rx_byte == CH_LF) && prev_cr_q && (line_len_q >= LEN_W'(2));
	assign pstat.malformed = comma_cnt_q < 3'd4;

	assign raw_pressure    = raw_p_q;
	assign raw_temperature = raw_t_q;

	// Saturate the comma count at five
	assign comma_next = (comma_cnt_q < 3'd5) ? comma_cnt_q + 3'd1 : comma_cnt_q;

	// Shift in one decimal digit, saturating at the reading's full scale
	always_comb begin
		acc_sel = (comma_cnt_q == 3'd3) ? raw_p_q : raw_t_q;
		acc_sum = {acc_sel, 3'b000} + ACC_W'({acc_sel, 1'b0})
			+ ACC_W'(rx_byte[3:0]);
		if (acc_sum[ACC_W-1:READING_BITS] != '0) begin
			acc_next = '1;
		end else begin
			acc_next = acc_sum[READING_BITS-1:0];
		end
	end

	// Advance the line state on each taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q  <= '0;
			comma_cnt_q <= '0;
			prev_cr_q   <= 1'b0;
			digits_q    <= 1'b0;
			raw_p_q     <= '0;
			raw_t_q     <= '0;
		end else if (take) begin
			if (pstat.line_end || line_full) begin
				line_len_q  <= '0;
				comma_cnt_q <= '0;
				prev_cr_q   <= 1'b0;
				digits_q    <= 1'b0;
				raw_p_q     <= '0;
				raw_t_q     <= '0;
			end else begin
				line_len_q <= line_len_q + LEN_W'(1);
				prev_cr_q  <= (rx_byte == CH_CR);
				if (rx_byte == CH_COMMA) begin
					comma_cnt_q <= comma_next;
					digits_q    <= (comma_next == 3'd3) || (comma_next == 3'd4);
				end else if (digits_q && is_digit) begin
					if (comma_cnt_q == 3'd3) begin
						raw_p_q <= acc_next;
					end else begin
						raw_t_q <= acc_next;
					end
				end else begin
					digits_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTH
	// The kept byte count never passes the line limit
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LEN_W'(LINE_MAX))
		else $error("line length beyond limit");
`endif

endmodule

[rtl/altlpc_ctrl.sv]
// ----------------------------------------------------------------------------
// altlpc_ctrl
// Controller of the compensation: takes bytes while idle and, at a
// well-formed line end, steps the datapath through its multiply sequence;
// every line end hands a result or malformed status to the output register.
// ----------------------------------------------------------------------------
module altlpc_ctrl
	import altlpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	input  pstat_t pstat,
	input  logic   out_free,
	output logic   s_tready,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_d;
	logic   take;

	assign take = s_tvalid && s_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && pstat.line_end) begin
					state_d = pstat.malformed ? ST_DONE : ST_MUL_T;
				end
			end
			ST_MUL_T:  state_d = ST_MUL_O;
			ST_MUL_O:  state_d = ST_MUL_S;
			ST_MUL_S:  state_d = ST_SENS;
			ST_SENS:   state_d = ST_MUL_PL;
			ST_MUL_PL: state_d = ST_MUL_PH;
			ST_MUL_PH: state_d = ST_PSUM;
			ST_PSUM:   state_d = ST_PDIFF;
			ST_PDIFF:  state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = 1'b0;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && pstat.line_end) begin
					cmd.op = OP_LOAD;
				end
			end
			ST_MUL_T:  cmd.op = OP_MUL_T;
			ST_MUL_O:  cmd.op = OP_MUL_O;
			ST_MUL_S:  cmd.op = OP_MUL_S;
			ST_SENS:   cmd.op = OP_SENS;
			ST_MUL_PL: cmd.op = OP_MUL_PL;
			ST_MUL_PH: cmd.op = OP_MUL_PH;
			ST_PSUM:   cmd.op = OP_PSUM;
			ST_PDIFF:  cmd.op = OP_PDIFF;
			ST_DONE: begin
				if (out_free) begin
					cmd.op = OP_PUBLISH;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// A well-formed line end starts the multiply sequence
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && pstat.line_end && !pstat.malformed |=> state_q == ST_MUL_T)
		else $error("well-formed line end did not start compensation");
	// A malformed line end goes straight to the result
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		take && pstat.line_end && pstat.malformed |=> state_q == ST_DONE)
		else $error("malformed line end did not go to result");
	// Hold a finished result while the output register is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_free |=> state_q == ST_DONE)
		else $error("result dropped while output busy");
`endif

endmodule

[rtl/altlpc_dp.sv]
// ----------------------------------------------------------------------------
// altlpc_dp
// Compensation datapath: one shared multiplier with a registered product,
// sign and magnitude handling of dT, OFF and SENS, a two-slice wide product
// for P and the final truncation and saturation of P and TEMP.
// ----------------------------------------------------------------------------
module altlpc_dp
	import altlpc_pkg::*;
#(
	parameter int READING_BITS = 24
) (
	input  logic                    clk,
	input  cmd_t                    cmd,
	input  pstat_t                  pstat,
	input  logic [READING_BITS-1:0] raw_pressure,
	input  logic [READING_BITS-1:0] raw_temperature,
	input  coeff_t                  coeff,
	output logic signed [P_W-1:0]   pressure_centi,
	output logic signed [T_W-1:0]   temperature_centi,
	output logic                    status
);

	// |dT| width, product width and derived term widths
	localparam int DMW  = (READING_BITS > 24) ? READING_BITS : 24;
	localparam int PW   = DMW + MB_W;
	localparam int TW   = DMW - 5;
	localparam int OW   = DMW + 12;
	localparam int SMW  = DMW + 10;
	localparam int FW   = READING_BITS + SMW;
	localparam int QW   = FW - 21;
	localparam int SUMW = PW + 24;
	localparam int VW   = ((QW > OW) ? QW : OW) + 2;

	logic [READING_BITS-1:0] d1_q;
	logic [DMW-1:0]          dtmag_q;
	logic                    dtneg_q;
	logic                    bad_q;
	logic [PW-1:0]           prod_q;
	logic [PW-1:0]           acc_q;
	logic signed [T_W-1:0]   temp_q;
	logic signed [OW-1:0]    off_q;
	logic [SMW-1:0]          sens_mag_q;
	logic                    sens_neg_q;
	logic [QW-1:0]           q_q;
	logic signed [VW-1:0]    v_q;

	logic [DMW-1:0]          d2_w;
	logic [DMW-1:0]          ref_w;
	logic [DMW-1:0]          mul_a;
	logic [MB_W-1:0]         mul_b;
	logic signed [TW-1:0]    tmag_w;
	logic signed [TW-1:0]    temp_w;
	logic signed [T_W-1:0]   temp_sat;
	logic signed [OW-1:0]    offm_w;
	logic signed [OW-1:0]    offb_w;
	logic [SMW-1:0]          sensm_w;
	logic [SMW-1:0]          sensb_w;
	logic [SUMW-1:0]         sum_w;
	logic signed [VW-1:0]    qx_w;
	logic signed [VW-1:0]    offx_w;
	logic signed [VW-1:0]    pv_w;

	// dT as sign and magnitude
	assign d2_w  = DMW'(raw_temperature);
	assign ref_w = DMW'({coeff.ref_temp_coeff, 8'h00});

	// Select the multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_T: begin
				mul_a = dtmag_q;
				mul_b = MB_W'(coeff.temp_slope_coeff);
			end
			OP_MUL_O: begin
				mul_a = dtmag_q;
				mul_b = MB_W'(coeff.offset_temp_coeff);
			end
			OP_MUL_S: begin
				mul_a = dtmag_q;
				mul_b = MB_W'(coeff.sens_temp_coeff);
			end
			OP_MUL_PL: begin
				mul_a = DMW'(d1_q);
				mul_b = sens_mag_q[MB_W-1:0];
			end
			OP_MUL_PH: begin
				mul_a = DMW'(d1_q);
				mul_b = MB_W'(sens_mag_q[SMW-1:MB_W]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// TEMP = 2000 +/- (|dT| * slope >> 23), saturated
	always_comb begin
		tmag_w = $signed({2'b00, prod_q[DMW+15:23]});
		temp_w = dtneg_q ? TW'(TEMP_BASE) - tmag_w : TW'(TEMP_BASE) + tmag_w;
		if (temp_w > TW'(TEMP_LIMIT)) begin
			temp_sat = T_W'(TEMP_LIMIT);
		end else if (temp_w < TW'(-TEMP_LIMIT)) begin
			temp_sat = T_W'(-TEMP_LIMIT);
		end else begin
			temp_sat = T_W'(temp_w);
		end
	end

	// OFF = offset << 17 +/- (|dT| * off_temp >> 6)
	assign offm_w = $signed({2'b00, prod_q[DMW+15:6]});
	assign offb_w = $signed(OW'({coeff.offset_coeff, 17'h00000}));

	// SENS operands: sens << 16 and |dT| * sens_temp >> 7
	assign sensm_w = SMW'(prod_q[DMW+15:7]);
	assign sensb_w = SMW'({coeff.sens_coeff, 16'h0000});

	// Join the two product slices of D1 * |SENS|
	assign sum_w = SUMW'(acc_q) + {1'b0, prod_q, 23'h000000};

	assign qx_w   = $signed(VW'(q_q));
	assign offx_w = VW'(off_q);

	// P = (q - OFF) / 2^15 toward zero
	always_comb begin
		if (v_q[VW-1]) begin
			pv_w = (v_q + VW'(32767)) >>> 15;
		end else begin
			pv_w = v_q >>> 15;
		end
	end

	// Run one step of the sequence
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				d1_q    <= raw_pressure;
				bad_q   <= pstat.malformed;
				dtneg_q <= d2_w < ref_w;
				dtmag_q <= (d2_w < ref_w) ? ref_w - d2_w : d2_w - ref_w;
			end
			OP_MUL_T: begin
				prod_q <= PW'(mul_a * mul_b);
			end
			OP_MUL_O: begin
				temp_q <= temp_sat;
				prod_q <= PW'(mul_a * mul_b);
			end
			OP_MUL_S: begin
				off_q  <= dtneg_q ? offb_w - offm_w : offb_w + offm_w;
				prod_q <= PW'(mul_a * mul_b);
			end
			OP_SENS: begin
				if (!dtneg_q) begin
					sens_mag_q <= sensb_w + sensm_w;
					sens_neg_q <= 1'b0;
				end else if (sensb_w >= sensm_w) begin
					sens_mag_q <= sensb_w - sensm_w;
					sens_neg_q <= 1'b0;
				end else begin
					sens_mag_q <= sensm_w - sensb_w;
					sens_neg_q <= 1'b1;
				end
			end
			OP_MUL_PL: begin
				prod_q <= PW'(mul_a * mul_b);
			end
			OP_MUL_PH: begin
				acc_q  <= prod_q;
				prod_q <= PW'(mul_a * mul_b);
			end
			OP_PSUM: begin
				q_q <= sum_w[FW-1:21];
			end
			OP_PDIFF: begin
				v_q <= sens_neg_q ? -qx_w - offx_w : qx_w - offx_w;
			end
			default: begin
			end
		endcase
	end

	// Saturate P and mask a malformed line
	always_comb begin
		status            = bad_q;
		temperature_centi = bad_q ? '0 : temp_q;
		if (bad_q) begin
			pressure_centi = '0;
		end else if (pv_w > VW'(P_MAX)) begin
			pressure_centi = P_W'(P_MAX);
		end else if (pv_w < VW'(P_MIN)) begin
			pressure_centi = P_W'(P_MIN);
		end else begin
			pressure_centi = P_W'(pv_w);
		end
	end

endmodule

[rtl/altimeter_line_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// altimeter_line_pressure_compensation
// Reads altimeter text lines one byte per item and, at each CR LF line end,
// emits compensated pressure and temperature or a malformed-line status.
// ----------------------------------------------------------------------------
// Ordinary bytes: one item per cycle while idle, no result.
// Line end: input held while the shared multiplier runs five products in
//   sequence through the states MUL_T to PDIFF, then DONE loads the output
//   register (a malformed line goes straight to DONE); a full output register stalls DONE.
// Reset: line state and handshakes clear at once; coefficients take their
//   default values; no clearing pass.
module altimeter_line_pressure_compensation
	import altlpc_pkg::*;
#(
	parameter int LINE_MAX     = 256,
	parameter int READING_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [24:0] pressure_centi, [43:25] temperature_centi
	output logic        m_tuser,   // [0] status
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	coeff_t                  coeff_q;
	pstat_t                  pstat;
	cmd_t                    cmd;
	logic                    take;
	logic                    out_free;
	logic [READING_BITS-1:0] raw_pressure;
	logic [READING_BITS-1:0] raw_temperature;
	logic signed [P_W-1:0]   pressure_centi;
	logic signed [T_W-1:0]   temperature_centi;
	logic                    status;
	logic                    m_valid_q;
	logic [P_W-1:0]          m_p_q;
	logic [T_W-1:0]          m_t_q;
	logic                    m_status_q;

	assign take     = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign pready   = 1'b1;

	// Write the coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q.sens_coeff        <= RST_SENS;
			coeff_q.offset_coeff      <= RST_OFFSET;
			coeff_q.sens_temp_coeff   <= RST_SENS_TEMP;
			coeff_q.offset_temp_coeff <= RST_OFF_TEMP;
			coeff_q.ref_temp_coeff    <= RST_REF_TEMP;
			coeff_q.temp_slope_coeff  <= RST_SLOPE;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_SENS:      coeff_q.sens_coeff        <= pwdata[COEFF_W-1:0];
				REG_OFFSET:    coeff_q.offset_coeff      <= pwdata[COEFF_W-1:0];
				REG_SENS_TEMP: coeff_q.sens_temp_coeff   <= pwdata[COEFF_W-1:0];
				REG_OFF_TEMP:  coeff_q.offset_temp_coeff <= pwdata[COEFF_W-1:0];
				REG_REF_TEMP:  coeff_q.ref_temp_coeff    <= pwdata[COEFF_W-1:0];
				REG_SLOPE:     coeff_q.temp_slope_coeff  <= pwdata[COEFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the coefficient registers
	always_comb begin
		case (paddr[4:2])
			REG_SENS:      prdata = 32'(coeff_q.sens_coeff);
			REG_OFFSET:    prdata = 32'(coeff_q.offset_coeff);
			REG_SENS_TEMP: prdata = 32'(coeff_q.sens_temp_coeff);
			REG_OFF_TEMP:  prdata = 32'(coeff_q.offset_temp_coeff);
			REG_REF_TEMP:  prdata = 32'(coeff_q.ref_temp_coeff);
			REG_SLOPE:     prdata = 32'(coeff_q.temp_slope_coeff);
			default:       prdata = '0;
		endcase
	end

	altlpc_parser #(
		.LINE_MAX     (LINE_MAX),
		.READING_BITS (READING_BITS)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.rx_byte         (s_tdata),
		.pstat           (pstat),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature)
	);

	altlpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.pstat    (pstat),
		.out_free (out_free),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	altlpc_dp #(
		.READING_BITS (READING_BITS)
	) u_dp (
		.clk               (clk),
		.cmd               (cmd),
		.pstat             (pstat),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.coeff             (coeff_q),
		.pressure_centi    (pressure_centi),
		.temperature_centi (temperature_centi),
		.status            (status)
	);

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.op == OP_PUBLISH) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			m_p_q      <= pressure_centi;
			m_t_q      <= temperature_centi;
			m_status_q <= status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, m_t_q, m_p_q};
	assign m_tuser  = m_status_q;

`ifndef SYNTH
	// A published result is offered on the next cycle
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PUBLISH |=> m_tvalid)
		else $error("published result not offered");
`endif

endmodule

[dv/altimeter_fix_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// altimeter_fix_checker
// Watches the byte stream, the configuration port and the result stream of
// the altimeter line pressure compensation block. Keeps its own copy of the
// line parser and coefficients, predicts each result item and compares it
// field by field with what the block emits.
// ----------------------------------------------------------------------------
module altimeter_fix_checker
	import altlpc_pkg::*;
#(
	parameter int LINE_MAX     = 256,
	parameter int READING_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,    // [24:0] pressure_centi, [43:25] temperature_centi
	input  logic        m_tuser,    // [0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int unsigned outstanding,
	output int unsigned fail_count
);

	localparam int MAX_REPORTS = 10;
	localparam longint READING_MAX = (64'sd1 <<< READING_BITS) - 1;

	typedef struct packed {
		logic signed [P_W-1:0] pressure_centi;
		logic signed [T_W-1:0] temperature_centi;
		logic                  status;
	} alt_fix_t;

	// Coefficient copy
	logic [COEFF_W-1:0] k_sens, k_off, k_sens_temp, k_off_temp, k_ref, k_slope;

	// Line parser copy
	int unsigned              line_len;
	logic [2:0]               commas;
	bit                       after_cr;
	bit                       in_reading;
	logic [READING_BITS-1:0]  raw_p, raw_t;

	alt_fix_t    fix_q[$];
	int unsigned fail_cnt;
	int unsigned result_idx;

	assign fail_count = fail_cnt;

	// Divide by 2^sh, rounding toward zero
	function automatic longint shr_toward_zero(longint v, int unsigned sh);
		return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
	endfunction

	function automatic void clear_line();
		line_len   = 0;
		commas     = '0;
		after_cr   = 1'b0;
		in_reading = 1'b0;
		raw_p      = '0;
		raw_t      = '0;
	endfunction

	// First-order compensation on exact integers
	function automatic alt_fix_t compensate_fix();
		longint   d_t, temp, off, sens, p;
		alt_fix_t f;
		d_t  = longint'(raw_t) - longint'(k_ref) * 256;
		temp = TEMP_BASE + shr_toward_zero(d_t * longint'(k_slope), 23);
		off  = longint'(k_off) * 131072 + shr_toward_zero(d_t * longint'(k_off_temp), 6);
		sens = longint'(k_sens) * 65536 + shr_toward_zero(d_t * longint'(k_sens_temp), 7);
		p    = shr_toward_zero(shr_toward_zero(longint'(raw_p) * sens, 21) - off, 15);
		if (p > P_MAX) p = P_MAX;
		if (p < P_MIN) p = P_MIN;
		if (temp > TEMP_LIMIT) temp = TEMP_LIMIT;
		if (temp < -TEMP_LIMIT) temp = -TEMP_LIMIT;
		f.pressure_centi    = p[P_W-1:0];
		f.temperature_centi = temp[T_W-1:0];
		f.status            = 1'b0;
		return f;
	endfunction

	// Advance the parser by one byte, queue a fix at line end
	function automatic void take_byte(logic [7:0] b);
		alt_fix_t f;
		longint   acc;
		if (b == CH_LF && after_cr && line_len >= 2) begin
			if (commas < 4) begin
				f = '0;
				f.status = 1'b1;
			end else begin
				f = compensate_fix();
			end
			fix_q.push_back(f);
			clear_line();
		end else if (line_len >= LINE_MAX) begin
			// overlong line: drop the byte and the whole line
			clear_line();
		end else begin
			line_len++;
			after_cr = (b == CH_CR);
			if (b == CH_COMMA) begin
				if (commas < 5) commas++;
				in_reading = (commas == 3 || commas == 4);
			end else if (in_reading && b >= CH_ZERO && b <= CH_NINE) begin
				acc = longint'(commas == 3 ? raw_p : raw_t) * 10 + longint'(b - CH_ZERO);
				if (acc > READING_MAX) acc = READING_MAX;
				if (commas == 3) raw_p = acc[READING_BITS-1:0];
				else raw_t = acc[READING_BITS-1:0];
			end else begin
				in_reading = 1'b0;
			end
		end
	endfunction

	function automatic void report(string what);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS) begin
			$display("[%0t] result %0d: %s", $time, result_idx, what);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alt_fix_t want;
		if (!arst_n) begin
			k_sens      = RST_SENS;
			k_off       = RST_OFFSET;
			k_sens_temp = RST_SENS_TEMP;
			k_off_temp  = RST_OFF_TEMP;
			k_ref       = RST_REF_TEMP;
			k_slope     = RST_SLOPE;
			clear_line();
			fix_q.delete();
			result_idx = 0;
			outstanding <= 0;
		end else begin
			// Track coefficient writes; spare addresses are ignored
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_SENS:      k_sens      = pwdata[COEFF_W-1:0];
					REG_OFFSET:    k_off       = pwdata[COEFF_W-1:0];
					REG_SENS_TEMP: k_sens_temp = pwdata[COEFF_W-1:0];
					REG_OFF_TEMP:  k_off_temp  = pwdata[COEFF_W-1:0];
					REG_REF_TEMP:  k_ref       = pwdata[COEFF_W-1:0];
					REG_SLOPE:     k_slope     = pwdata[COEFF_W-1:0];
					default: ;
				endcase
			end

			// Compare before queueing: a result never stems from a byte of the same edge
			if (m_tvalid && m_tready) begin
				if (fix_q.size() == 0) begin
					report($sformatf("unexpected item p=%0d t=%0d status=%0b",
						$signed(m_tdata[24:0]), $signed(m_tdata[43:25]), m_tuser));
				end else begin
					want = fix_q.pop_front();
					if (m_tdata[24:0] !== want.pressure_centi
						|| m_tdata[43:25] !== want.temperature_centi
						|| m_tuser !== want.status) begin
						report($sformatf("expected p=%0d t=%0d status=%0b, got p=%0d t=%0d status=%0b",
							want.pressure_centi, want.temperature_centi, want.status,
							$signed(m_tdata[24:0]), $signed(m_tdata[43:25]), m_tuser));
					end
				end
				result_idx++;
			end

			if (s_tvalid && s_tready) take_byte(s_tdata);

			outstanding <= fix_q.size();
		end
	end

endmodule

[dv/tb_altimeter_line_pressure_compensation.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_altimeter_line_pressure_compensation
// Feeds altimeter text lines byte by byte: a short set of hand-written lines,
// lines at and past the length limit, then random well-formed lines mixed
// with malformed lines and noise under several coefficient settings. Both
// stream sides idle at random; a checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_altimeter_line_pressure_compensation;
	import altlpc_pkg::*;

	localparam int LINE_MAX       = 256;
	localparam int RANDOM_ITEMS   = 860;
	localparam int RANDOM_PHASES  = 6;
	localparam int MIN_LINES      = 25;
	localparam int DRAIN_SLACK    = 16;
	localparam int RX_HOLD_CYCLES = 400;
	// Slowest run is near 2000 bytes with random gaps plus result stalls: allow far more
	localparam int CYCLE_LIMIT    = 600000;

	// Addresses above the last register, ignored by the block
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;      // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;            // [24:0] pressure_centi, [43:25] temperature_centi
	logic        m_tuser;            // [0] status
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned lines_sent = 0;
	bit          rx_hold_req = 1'b0;
	bit          tx_quiet = 1'b0;
	int unsigned tx_run = 0;
	logic [7:0]  line_buf[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	altimeter_line_pressure_compensation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	altimeter_fix_checker #(
		.LINE_MAX     (LINE_MAX),
		.READING_BITS (24)
	) fix_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Line text builders
	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void put_number(longint unsigned v);
		put_text($sformatf("%0d", v));
	endfunction

	function automatic void put_line_end();
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endfunction

	// Raw reading: zero, full scale, overflow, small, typical or anywhere
	function automatic longint unsigned pick_raw();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return longint'($urandom) * 64'd1000000 + $urandom_range(0, 999999);
			3: return $urandom_range(0, 999);
			4, 5: return $urandom_range(6000000, 9000000);
			default: return $urandom_range(0, 24'hFFFFFF);
		endcase
	endfunction

	// Reading field with junk: empty, leading non-digit, split digits, trailing junk
	function automatic void put_odd_field();
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				put_text("x");
				put_number($urandom_range(0, 99999));
			end
			2: begin
				put_number($urandom_range(0, 99999));
				put_text("a");
				put_number($urandom_range(0, 99999));
			end
			3: begin
				put_text("-");
				put_number($urandom_range(0, 99999));
			end
			default: begin
				put_number(pick_raw());
				put_text(" ");
			end
		endcase
	endfunction

	function automatic void build_random_line();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			// well-formed line, sometimes with trailing fields past the fifth comma
			put_text("$ALT,");
			put_number($urandom_range(0, 9999));
			put_text(",");
			put_number($urandom_range(0, 235959));
			put_text(",");
			put_number(pick_raw());
			put_text(",");
			put_number(pick_raw());
			repeat ($urandom_range(0, 3)) begin
				put_text(",");
				put_number($urandom_range(0, 999));
			end
		end else if (kind < 72) begin
			put_text(",,,");
			put_odd_field();
			put_text(",");
			put_odd_field();
		end else if (kind < 84) begin
			// fewer than four commas
			repeat ($urandom_range(0, 3)) begin
				put_number($urandom_range(0, 99999));
				put_text(",");
			end
			put_number($urandom_range(0, 99999));
		end else if (kind < 95) begin
			repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom));
		end else begin
			// stray CR and LF at line start
			case ($urandom_range(0, 2))
				0: line_buf.push_back(CH_CR);
				1: line_buf.push_back(CH_LF);
				default: begin
					line_buf.push_back(CH_CR);
					line_buf.push_back(CH_CR);
				end
			endcase
		end
		put_line_end();
	endfunction

	// Offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Send the buffered bytes; gap mode holds for a run of lines
	task automatic send_line();
		if (tx_run == 0) begin
			tx_quiet = ($urandom_range(0, 2) == 0);
			tx_run   = $urandom_range(1, 6);
		end
		tx_run--;
		foreach (line_buf[i]) send_byte(line_buf[i]);
		line_buf.delete();
		lines_sent++;
	endtask

	task automatic send_text_line(input string s);
		put_text(s);
		put_line_end();
		send_line();
	endtask

	// Stop offering and wait for every expected result, then let the block settle
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_coeff(input logic [2:0] idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_coeffs(input int setting);
		logic [15:0] v [6];
		case (setting)
			1: foreach (v[i]) v[i] = 16'hFFFF;
			2: foreach (v[i]) v[i] = 16'h0000;
			4: v = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
			5: v = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
			default: foreach (v[i]) v[i] = 16'($urandom);
		endcase
		write_coeff(REG_SENS, v[0]);
		write_coeff(REG_OFFSET, v[1]);
		write_coeff(REG_SENS_TEMP, v[2]);
		write_coeff(REG_OFF_TEMP, v[3]);
		write_coeff(REG_REF_TEMP, v[4]);
		write_coeff(REG_SLOPE, v[5]);
		write_coeff(REG_SPARE_LO, 16'($urandom));
		write_coeff(REG_SPARE_HI, 16'($urandom));
	endtask

	// Result side: random back-pressure, plus one long hold-off on request
	initial begin
		int gap;
		int run_left;
		bit quiet;
		run_left = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			if (run_left == 0) begin
				quiet    = ($urandom_range(0, 2) == 0);
				run_left = $urandom_range(1, 10);
			end
			run_left--;
			gap = quiet ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned random_start;
		int unsigned random_lines;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-written lines under reset coefficients
		send_text_line(",,,6465444,8077636");
		send_text_line(",,,0,0");
		send_text_line(",,,16777215,16777215");
		send_text_line(",,,99999999999,123456789012");
		send_text_line(",,");
		send_text_line("");                  // bare CR LF at line start continues the line
		send_text_line(",,,5,6");
		send_text_line(",,,x12,7y8");
		send_text_line(",,,12a34,56");
		send_text_line(",,,/5,:7");
		send_text_line(",,,1,2,3,4,5");
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		line_buf.push_back(8'h00);
		put_text(",,,");
		line_buf.push_back(8'h7F);
		put_text(",1");
		put_line_end();
		send_line();
		put_text("a");
		line_buf.push_back(CH_CR);
		put_line_end();
		send_line();
		line_buf.push_back(CH_LF);
		put_line_end();
		send_line();

		// Line length limit: exactly full, then overlong, then dropped CR
		put_text(",,,123,456");
		while (line_buf.size() < LINE_MAX - 1) put_text("z");
		put_line_end();
		send_line();
		repeat (LINE_MAX + 44) line_buf.push_back("q");
		send_text_line(",,,1,1");
		repeat (LINE_MAX) line_buf.push_back("z");
		put_line_end();
		send_line();
		send_text_line(",,,7,7");
		wait_results_drained();

		// Random lines under several coefficient settings
		random_start = bytes_sent;
		random_lines = lines_sent;
		for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
			program_coeffs(phase);
			if (phase == 2) begin
				// hold off the receiver while short lines pile up behind it
				rx_hold_req = 1'b1;
				tx_quiet    = 1'b1;
				tx_run      = 12;
				repeat (12) begin
					put_text(",,,");
					put_number(pick_raw());
					put_text(",");
					put_number(pick_raw());
					put_line_end();
					send_line();
				end
			end
			while (bytes_sent - random_start < phase * RANDOM_ITEMS / RANDOM_PHASES
				|| (phase == RANDOM_PHASES && lines_sent - random_lines < MIN_LINES)) begin
				build_random_line();
				send_line();
			end
			wait_results_drained();
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/altlpc_pkg.sv
rtl/altlpc_parser.sv
rtl/altlpc_ctrl.sv
rtl/altlpc_dp.sv
rtl/altimeter_line_pressure_compensation.sv
dv/altimeter_fix_checker.sv
dv/tb_altimeter_line_pressure_compensation.sv
